>>> rtl/core/tlbpt_pkg.sv
package tlbpt_pkg;

   // Address split and table sizes
   localparam int PAGE_COUNT  = 256;
   localparam int FRAME_COUNT = 128;
   localparam int TLB_ENTRIES = 16;
   localparam int OFFSET_BITS = 8;

   // Port widths fixed by the interface
   localparam int ADDR_W = 16;
   localparam int PA_W   = 15;
   localparam int DATA_W = 8;
   localparam int CFG_W  = 8;
   localparam int CNT_W  = 32;

   // Derived widths
   localparam int PAGE_W  = $clog2(PAGE_COUNT);
   localparam int FRAME_W = $clog2(FRAME_COUNT);
   localparam int TLB_W   = $clog2(TLB_ENTRIES);
   localparam int LIMIT_W = $clog2(FRAME_COUNT + 1);

   localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = CFG_W'(128);

   // Clamp the programmed frame limit into 1 .. FRAME_COUNT
   function automatic logic [LIMIT_W-1:0] frame_limit(input logic [CFG_W-1:0] value);
      logic [LIMIT_W-1:0] limit;
      if (value == '0) begin
         limit = LIMIT_W'(1);
      end else if (int'(value) > FRAME_COUNT) begin
         limit = LIMIT_W'(FRAME_COUNT);
      end else begin
         limit = LIMIT_W'(value);
      end
      return limit;
   endfunction

endpackage

>>> rtl/core/tlb_page_table_translator.sv
// A beat accepted (start high, busy low) is captured in page_ff, offset_ff and the memory
// read registers, then looked up and written back; its result holds the rsp_ ports,
// rsp_valid high, for one cycle. The receiver cannot stall results. Busy blocks a new beat
// until the page-map and frame-owner memories (one read port each) are read and written back.
// Reset (synchronous, active high): clear page-map and TLB valid bits, pointers and
// counters, load frames_in_use with 128; busy stays high while reset is asserted.
module tlb_page_table_translator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [tlbpt_pkg::ADDR_W-1:0]          req_logical_address,
   output logic                                  rsp_valid,
   output logic [tlbpt_pkg::PA_W-1:0]            rsp_phys_addr,
   output logic signed [tlbpt_pkg::DATA_W-1:0]   rsp_data_value,
   output logic                                  rsp_tlb_hit,
   output logic                                  rsp_page_fault,
   output logic                                  rsp_evicted,
   output logic [tlbpt_pkg::CNT_W-1:0]           rsp_hit_count,
   output logic [tlbpt_pkg::CNT_W-1:0]           rsp_fault_count,
   output logic [tlbpt_pkg::CNT_W-1:0]           rsp_address_count,
   input  logic                                  csr_write_enable,
   input  logic [tlbpt_pkg::CFG_W-1:0]           csr_write_data
);

   localparam int PAGE_W  = tlbpt_pkg::PAGE_W;
   localparam int FRAME_W = tlbpt_pkg::FRAME_W;
   localparam int TLB_W   = tlbpt_pkg::TLB_W;
   localparam int LIMIT_W = tlbpt_pkg::LIMIT_W;
   localparam int CNT_W   = tlbpt_pkg::CNT_W;
   localparam int OFF_W   = tlbpt_pkg::OFFSET_BITS;
   localparam int NTLB    = tlbpt_pkg::TLB_ENTRIES;
   localparam int NPAGE   = tlbpt_pkg::PAGE_COUNT;
   localparam int NFRAME  = tlbpt_pkg::FRAME_COUNT;

   // Memories: page -> frame (validity kept in flops), frame -> owning page
   logic [FRAME_W-1:0] page_map_mem    [NPAGE];
   logic [PAGE_W-1:0]  frame_owner_mem [NFRAME];

   // Control state
   logic                      busy_ff;
   logic [tlbpt_pkg::CFG_W-1:0] frames_in_use_ff, frames_in_use_in;
   logic                      map_valid_ff [NPAGE];
   logic                      map_valid_in [NPAGE];
   logic                      tlb_valid_ff [NTLB];
   logic                      tlb_valid_in [NTLB];
   logic [TLB_W-1:0]          tlb_fill_ff, tlb_fill_in;
   logic [LIMIT_W-1:0]        alloc_ff, alloc_in;
   logic [FRAME_W-1:0]        victim_ff, victim_in;
   logic [CNT_W-1:0]          hits_ff, hits_in;
   logic [CNT_W-1:0]          faults_ff, faults_in;
   logic [CNT_W-1:0]          addrs_ff, addrs_in;
   logic                      rsp_valid_ff;

   // Payload state
   logic [PAGE_W-1:0]         tlb_tag_ff   [NTLB];
   logic [PAGE_W-1:0]         tlb_tag_in   [NTLB];
   logic [FRAME_W-1:0]        tlb_frame_ff [NTLB];
   logic [FRAME_W-1:0]        tlb_frame_in [NTLB];
   logic [PAGE_W-1:0]         page_ff;
   logic [OFF_W-1:0]          offset_ff;
   logic [FRAME_W-1:0]        map_rd_ff;
   logic [PAGE_W-1:0]         owner_rd_ff;
   logic [tlbpt_pkg::PA_W-1:0] pa_ff, pa_in;
   logic [tlbpt_pkg::DATA_W-1:0] data_ff;
   logic                      hit_ff, fault_ff, evict_ff;
   logic                      hit_in, fault_in, evict_in;

   // Combinational helpers
   logic                      accept;
   logic [PAGE_W-1:0]         req_page;
   logic [OFF_W-1:0]          req_offset;
   logic [LIMIT_W-1:0]        limit;
   logic [FRAME_W-1:0]        victim_sel;
   logic [FRAME_W-1:0]        frame_sel;
   logic [FRAME_W-1:0]        tlb_hit_frame;
   logic                      tlb_match;
   logic                      map_we;

   assign busy       = busy_ff | reset;
   assign accept     = start & ~busy;
   assign req_page   = PAGE_W'(req_logical_address >> OFF_W);
   assign req_offset = req_logical_address[OFF_W-1:0];
   assign limit      = tlbpt_pkg::frame_limit(frames_in_use_ff);
   // Wrap the victim pointer when the limit was lowered under it
   assign victim_sel = (LIMIT_W'(victim_ff) >= limit) ? '0 : victim_ff;

   always_comb begin
      tlb_match     = 1'b0;
      tlb_hit_frame = '0;
      for (int i = 0; i < NTLB; i++) begin
         if (tlb_valid_ff[i] && (tlb_tag_ff[i] == page_ff)) begin
            tlb_match     = 1'b1;
            tlb_hit_frame = tlb_frame_ff[i];
         end
      end
   end

   // Limit writes; lookup and write-back in the cycle after a beat is accepted
   always_comb begin
      frames_in_use_in = csr_write_enable ? csr_write_data : frames_in_use_ff;
      map_valid_in     = map_valid_ff;
      tlb_valid_in     = tlb_valid_ff;
      tlb_tag_in       = tlb_tag_ff;
      tlb_frame_in     = tlb_frame_ff;
      tlb_fill_in      = tlb_fill_ff;
      alloc_in         = alloc_ff;
      victim_in        = victim_ff;
      hits_in          = hits_ff;
      faults_in        = faults_ff;
      addrs_in         = addrs_ff;
      hit_in           = 1'b0;
      fault_in         = 1'b0;
      evict_in         = 1'b0;
      frame_sel        = '0;
      map_we           = 1'b0;

      if (busy_ff) begin
         addrs_in = addrs_ff + 1'b1;
         if (tlb_match) begin
            hit_in    = 1'b1;
            frame_sel = tlb_hit_frame;
            hits_in   = hits_ff + 1'b1;
         end else begin
            if (map_valid_ff[page_ff]) begin
               frame_sel = map_rd_ff;
            end else begin
               fault_in  = 1'b1;
               faults_in = faults_ff + 1'b1;
               map_we    = 1'b1;
               if (alloc_ff < limit) begin
                  frame_sel = FRAME_W'(alloc_ff);
                  alloc_in  = alloc_ff + 1'b1;
               end else begin
                  // Replace the FIFO victim: unmap its owner, drop its TLB entries
                  evict_in  = 1'b1;
                  frame_sel = victim_sel;
                  victim_in = (LIMIT_W'(victim_sel) + 1'b1 == limit) ? '0
                              : victim_sel + 1'b1;
                  map_valid_in[owner_rd_ff] = 1'b0;
                  for (int i = 0; i < NTLB; i++) begin
                     if (tlb_valid_ff[i] && (tlb_frame_ff[i] == victim_sel)) begin
                        tlb_valid_in[i] = 1'b0;
                     end
                  end
               end
               map_valid_in[page_ff] = 1'b1;
            end
            // Refill the TLB in FIFO order
            tlb_valid_in[tlb_fill_ff] = 1'b1;
            tlb_tag_in[tlb_fill_ff]   = page_ff;
            tlb_frame_in[tlb_fill_ff] = frame_sel;
            tlb_fill_in = (tlb_fill_ff == TLB_W'(NTLB - 1)) ? '0 : tlb_fill_ff + 1'b1;
         end
      end
      pa_in = tlbpt_pkg::PA_W'({frame_sel, offset_ff});
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         frames_in_use_ff <= tlbpt_pkg::FRAMES_IN_USE_RESET;
         for (int i = 0; i < NPAGE; i++) map_valid_ff[i] <= 1'b0;
         for (int i = 0; i < NTLB; i++) tlb_valid_ff[i] <= 1'b0;
         tlb_fill_ff      <= '0;
         alloc_ff         <= '0;
         victim_ff        <= '0;
         hits_ff          <= '0;
         faults_ff        <= '0;
         addrs_ff         <= '0;
      end else begin
         busy_ff          <= accept;
         rsp_valid_ff     <= busy_ff;
         frames_in_use_ff <= frames_in_use_in;
         map_valid_ff     <= map_valid_in;
         tlb_valid_ff     <= tlb_valid_in;
         tlb_fill_ff      <= tlb_fill_in;
         alloc_ff         <= alloc_in;
         victim_ff        <= victim_in;
         hits_ff          <= hits_in;
         faults_ff        <= faults_in;
         addrs_ff         <= addrs_in;
      end
   end

   // Payload registers and memories
   always_ff @(posedge clock) begin
      tlb_tag_ff   <= tlb_tag_in;
      tlb_frame_ff <= tlb_frame_in;
      if (accept) begin
         page_ff     <= req_page;
         offset_ff   <= req_offset;
         map_rd_ff   <= page_map_mem[req_page];
         owner_rd_ff <= frame_owner_mem[victim_sel];
      end
      if (map_we) begin
         page_map_mem[page_ff]      <= frame_sel;
         frame_owner_mem[frame_sel] <= page_ff;
      end
      if (busy_ff) begin
         pa_ff    <= pa_in;
         // A mapped frame is always owned by the page that reached it
         data_ff  <= tlbpt_pkg::DATA_W'(page_ff);
         hit_ff   <= hit_in;
         fault_ff <= fault_in;
         evict_ff <= evict_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_phys_addr        = pa_ff;
   assign rsp_data_value       = data_ff;
   assign rsp_tlb_hit          = hit_ff;
   assign rsp_page_fault       = fault_ff;
   assign rsp_evicted          = evict_ff;
   assign rsp_hit_count        = hits_ff;
   assign rsp_fault_count      = faults_ff;
   assign rsp_address_count    = addrs_ff;

   // An accepted beat enters the lookup cycle, then its result shows once
   a_accept_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && !rsp_valid_ff)
      else $error("accepted beat did not enter the lookup cycle");

   a_work_result: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff && rsp_valid_ff)
      else $error("lookup cycle did not produce exactly one result beat");

   a_hit_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_tlb_hit && rsp_page_fault) && (!rsp_evicted || rsp_page_fault))
      else $error("inconsistent hit, fault and evict flags");

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> alloc_ff <= LIMIT_W'(NFRAME))
      else $error("frame allocation count ran past the frame count");

endmodule

>>> tb/tlb_page_table_translator_test.sv
`timescale 1ns / 1ps

module tlb_page_table_translator_test;

   // Run limits
   localparam int QUIET_LIMIT   = 1000;   // cycles with no beat on either side
   localparam int REPORT_LIMIT  = 10;     // mismatches printed in full
   localparam int PHASE_COUNT   = 9;
   localparam int PHASE_BEATS   = 160;
   localparam int HOT_PAGES     = 24;
   localparam int SETTLE_CYCLES = 4;

   // One translation as it appears on the rsp_ ports
   typedef struct packed {
      logic [tlbpt_pkg::PA_W-1:0]          phys_addr;
      logic signed [tlbpt_pkg::DATA_W-1:0] data_value;
      logic                                tlb_hit;
      logic                                page_fault;
      logic                                evicted;
      logic [tlbpt_pkg::CNT_W-1:0]         hit_count;
      logic [tlbpt_pkg::CNT_W-1:0]         fault_count;
      logic [tlbpt_pkg::CNT_W-1:0]         address_count;
   } translation_type;

   typedef enum logic {
      ROW_ACCESS,
      ROW_LIMIT
   } row_kind_type;

   // Directed stimulus row: an address beat or a frame-limit write
   typedef struct {
      row_kind_type                 kind;
      logic [tlbpt_pkg::ADDR_W-1:0] value;
      bit                           typed;
      translation_type              want;
   } plan_row_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic [tlbpt_pkg::ADDR_W-1:0]        req_logical_address;
   logic                                rsp_valid;
   logic [tlbpt_pkg::PA_W-1:0]          rsp_phys_addr;
   logic signed [tlbpt_pkg::DATA_W-1:0] rsp_data_value;
   logic                                rsp_tlb_hit;
   logic                                rsp_page_fault;
   logic                                rsp_evicted;
   logic [tlbpt_pkg::CNT_W-1:0]         rsp_hit_count;
   logic [tlbpt_pkg::CNT_W-1:0]         rsp_fault_count;
   logic [tlbpt_pkg::CNT_W-1:0]         rsp_address_count;
   logic                                csr_write_enable;
   logic [tlbpt_pkg::CFG_W-1:0]         csr_write_data;

   tlb_page_table_translator DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_logical_address  (req_logical_address),
      .rsp_valid            (rsp_valid),
      .rsp_phys_addr        (rsp_phys_addr),
      .rsp_data_value       (rsp_data_value),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_evicted          (rsp_evicted),
      .rsp_hit_count        (rsp_hit_count),
      .rsp_fault_count      (rsp_fault_count),
      .rsp_address_count    (rsp_address_count),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Translation predictor: its own copy of the page map, TLB, frame
   // owners, pointers and running totals.
   // ------------------------------------------------------------------
   logic [tlbpt_pkg::CFG_W-1:0] frame_limit_setting;
   bit               page_mapped [tlbpt_pkg::PAGE_COUNT];
   int unsigned      page_frame  [tlbpt_pkg::PAGE_COUNT];
   bit               tlb_live    [tlbpt_pkg::TLB_ENTRIES];
   int unsigned      tlb_page    [tlbpt_pkg::TLB_ENTRIES];
   int unsigned      tlb_frame   [tlbpt_pkg::TLB_ENTRIES];
   int unsigned      frame_page  [tlbpt_pkg::FRAME_COUNT];
   int unsigned      tlb_next;
   int unsigned      frames_handed;
   int unsigned      victim_next;
   logic [tlbpt_pkg::CNT_W-1:0] hits_seen;
   logic [tlbpt_pkg::CNT_W-1:0] faults_seen;
   logic [tlbpt_pkg::CNT_W-1:0] addresses_seen;

   // Refill the TLB in FIFO order
   function automatic void tlb_refill(input int unsigned page, input int unsigned frame);
      tlb_live[tlb_next]  = 1'b1;
      tlb_page[tlb_next]  = page;
      tlb_frame[tlb_next] = frame;
      tlb_next            = (tlb_next + 1) % tlbpt_pkg::TLB_ENTRIES;
   endfunction

   function automatic translation_type translate_page(
         input logic [tlbpt_pkg::ADDR_W-1:0] addr);
      translation_type r;
      int unsigned  page;
      int unsigned  offset;
      int unsigned  frame;
      int unsigned  limit;
      int unsigned  owner;
      bit           hit;
      bit           fault;
      bit           evict;
      page   = (addr >> tlbpt_pkg::OFFSET_BITS) % tlbpt_pkg::PAGE_COUNT;
      offset = addr & ((1 << tlbpt_pkg::OFFSET_BITS) - 1);
      // Clamp the programmed limit into 1 .. FRAME_COUNT
      limit  = 32'(frame_limit_setting);
      if (limit == 0) begin
         limit = 1;
      end
      if (limit > tlbpt_pkg::FRAME_COUNT) begin
         limit = tlbpt_pkg::FRAME_COUNT;
      end
      hit   = 1'b0;
      fault = 1'b0;
      evict = 1'b0;
      frame = 0;
      addresses_seen++;
      for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
         if (!hit && tlb_live[i] && tlb_page[i] == page) begin
            hit   = 1'b1;
            frame = tlb_frame[i] % tlbpt_pkg::FRAME_COUNT;
         end
      end
      if (hit) begin
         hits_seen++;
      end else if (page_mapped[page]) begin
         frame = page_frame[page] % tlbpt_pkg::FRAME_COUNT;
         tlb_refill(page, frame);
      end else begin
         fault = 1'b1;
         faults_seen++;
         if (frames_handed < limit) begin
            frame = frames_handed;
            frames_handed++;
         end else begin
            // Pointer left beyond a lowered limit restarts at frame 0
            if (victim_next >= limit) begin
               victim_next = 0;
            end
            frame       = victim_next;
            victim_next = (victim_next + 1) % limit;
            owner       = frame_page[frame] % tlbpt_pkg::PAGE_COUNT;
            // Unmap the old owner only if it still points here
            if (page_mapped[owner] && page_frame[owner] == frame) begin
               page_mapped[owner] = 1'b0;
            end
            for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
               if (tlb_live[i] && tlb_frame[i] == frame) begin
                  tlb_live[i] = 1'b0;
               end
            end
            evict = 1'b1;
         end
         page_mapped[page] = 1'b1;
         page_frame[page]  = frame;
         frame_page[frame] = page;
         tlb_refill(page, frame);
      end
      r.phys_addr     = tlbpt_pkg::PA_W'((frame << tlbpt_pkg::OFFSET_BITS) | offset);
      r.data_value    = tlbpt_pkg::DATA_W'(frame_page[frame]);
      r.tlb_hit       = hit;
      r.page_fault    = fault;
      r.evicted       = evict;
      r.hit_count     = hits_seen;
      r.fault_count   = faults_seen;
      r.address_count = addresses_seen;
      return r;
   endfunction

   function automatic string show(input translation_type t);
      return $sformatf("pa=%h data=%0d hit=%b fault=%b evict=%b hits=%0d faults=%0d addrs=%0d",
                       t.phys_addr, t.data_value, t.tlb_hit, t.page_fault,
                       t.evicted, t.hit_count, t.fault_count, t.address_count);
   endfunction

   // ------------------------------------------------------------------
   // Scoreboard: predict on every accepted address beat, check every
   // result strobe against the oldest pending translation.
   // ------------------------------------------------------------------
   translation_type pending_translations[$];
   int unsigned  error_count;
   bit           row_typed;      // current beat carries a hand-written expectation
   translation_type row_want;

   always @(posedge clock) begin : scoreboard
      translation_type got;
      translation_type want;
      if (reset) begin
         frame_limit_setting = tlbpt_pkg::FRAMES_IN_USE_RESET;
         for (int p = 0; p < tlbpt_pkg::PAGE_COUNT; p++) begin
            page_mapped[p] = 1'b0;
            page_frame[p]  = 0;
         end
         for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
            tlb_live[i]  = 1'b0;
            tlb_page[i]  = 0;
            tlb_frame[i] = 0;
         end
         for (int f = 0; f < tlbpt_pkg::FRAME_COUNT; f++) begin
            frame_page[f] = 0;
         end
         tlb_next       = 0;
         frames_handed  = 0;
         victim_next    = 0;
         hits_seen      = '0;
         faults_seen    = '0;
         addresses_seen = '0;
      end else begin
         // Check the strobe first so a beat accepted now can never match it
         if (rsp_valid === 1'b1) begin
            got.phys_addr     = rsp_phys_addr;
            got.data_value    = rsp_data_value;
            got.tlb_hit       = rsp_tlb_hit;
            got.page_fault    = rsp_page_fault;
            got.evicted       = rsp_evicted;
            got.hit_count     = rsp_hit_count;
            got.fault_count   = rsp_fault_count;
            got.address_count = rsp_address_count;
            if (pending_translations.size() == 0) begin
               if (error_count < REPORT_LIMIT) begin
                  $display("%0t: result with nothing pending: %s", $realtime, show(got));
               end
               error_count++;
            end else begin
               want = pending_translations.pop_front();
               if (got.phys_addr     !== want.phys_addr     ||
                   got.data_value    !== want.data_value    ||
                   got.tlb_hit       !== want.tlb_hit       ||
                   got.page_fault    !== want.page_fault    ||
                   got.evicted       !== want.evicted       ||
                   got.hit_count     !== want.hit_count     ||
                   got.fault_count   !== want.fault_count   ||
                   got.address_count !== want.address_count) begin
                  if (error_count < REPORT_LIMIT) begin
                     $display("%0t: mismatch\n   expected %s\n   actual   %s",
                              $realtime, show(want), show(got));
                  end
                  error_count++;
               end
            end
         end
         if (csr_write_enable) begin
            frame_limit_setting = csr_write_data;
         end
         if (start && !busy) begin
            // Advance the predictor always; a typed row overrides its output
            want = translate_page(req_logical_address);
            if (row_typed) begin
               want = row_want;
            end
            pending_translations.push_back(want);
         end
      end
   end

   // Watchdog: end the run when neither side moves a beat for too long
   int unsigned quiet_cycles;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   plan_row_type directed_plan[$];
   bit           gaps_on;          // sender may idle between beats
   int unsigned  uniform_share;    // percent of random pages drawn from the whole table
   logic [7:0]   hot_base;         // first page of this phase's working set
   int unsigned  beats_sent;

   function automatic void plan_access(input logic [tlbpt_pkg::ADDR_W-1:0] addr,
                                       input int typed, input int pa, input int data,
                                       input int hit, input int fault, input int evict,
                                       input int hits, input int faults, input int addrs);
      plan_row_type r;
      r.kind               = ROW_ACCESS;
      r.value              = addr;
      r.typed              = (typed != 0);
      r.want.phys_addr     = tlbpt_pkg::PA_W'(pa);
      r.want.data_value    = tlbpt_pkg::DATA_W'(data);
      r.want.tlb_hit       = (hit != 0);
      r.want.page_fault    = (fault != 0);
      r.want.evicted       = (evict != 0);
      r.want.hit_count     = tlbpt_pkg::CNT_W'(hits);
      r.want.fault_count   = tlbpt_pkg::CNT_W'(faults);
      r.want.address_count = tlbpt_pkg::CNT_W'(addrs);
      directed_plan.push_back(r);
   endfunction

   function automatic void plan_limit(input logic [tlbpt_pkg::CFG_W-1:0] value);
      plan_row_type r;
      r.kind  = ROW_LIMIT;
      r.value = tlbpt_pkg::ADDR_W'(value);
      r.typed = 1'b0;
      r.want  = '0;
      directed_plan.push_back(r);
   endfunction

   // Present one address beat and hold it until the block takes it
   task automatic send_address(input logic [tlbpt_pkg::ADDR_W-1:0] addr, input bit typed,
                               input translation_type want);
      while (gaps_on && $urandom_range(99) < 25) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start               <= 1'b1;
      req_logical_address <= addr;
      row_typed           <= typed;
      row_want            <= want;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      beats_sent++;
      @(negedge clock);
   endtask

   // Drain the block, then write the frame limit while it is idle
   task automatic write_frame_limit(input logic [tlbpt_pkg::CFG_W-1:0] value);
      start <= 1'b0;
      while (pending_translations.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [tlbpt_pkg::ADDR_W-1:0] random_address();
      logic [tlbpt_pkg::ADDR_W-tlbpt_pkg::OFFSET_BITS-1:0] page;
      logic [tlbpt_pkg::OFFSET_BITS-1:0]                   offset;
      int unsigned                                         roll;
      roll = $urandom_range(99);
      if (roll < uniform_share) begin
         page = 8'($urandom_range(tlbpt_pkg::PAGE_COUNT - 1));
      end else if (roll < uniform_share + 10) begin
         case ($urandom_range(3))
            0: page = '0;
            1: page = '1;
            2: page = 8'h7F;
            default: page = 8'h80;
         endcase
      end else begin
         // Working set a bit larger than the TLB: mixes TLB hits, table hits and faults
         page = hot_base + 8'($urandom_range(HOT_PAGES - 1));
      end
      if ($urandom_range(99) < 15) begin
         offset = $urandom_range(1) ? '1 : '0;
      end else begin
         offset = tlbpt_pkg::OFFSET_BITS'($urandom_range((1 << tlbpt_pkg::OFFSET_BITS) - 1));
      end
      return {page, offset};
   endfunction

   initial begin : stimulus
      logic [tlbpt_pkg::CFG_W-1:0] phase_limits[PHASE_COUNT];
      reset               = 1'b1;
      start               = 1'b0;
      req_logical_address = '0;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      row_typed           = 1'b0;
      row_want            = '0;
      error_count         = 0;
      quiet_cycles        = 0;
      beats_sent          = 0;
      gaps_on             = 1'b1;
      uniform_share       = 30;
      hot_base            = '0;

      // Directed part. Values after reset: frames handed out in order 0, 1, 2 ...
      plan_access(16'h0000, 1, 'h0000,    0, 0, 1, 0, 0,  1,  1);  // first fault, frame 0
      plan_access(16'h00FF, 1, 'h00FF,    0, 1, 0, 0, 1,  1,  2);  // same page, TLB hit
      plan_access(16'hFFFF, 1, 'h01FF,   -1, 0, 1, 0, 1,  2,  3);  // top page, data -1
      plan_access(16'hFF00, 1, 'h0100,   -1, 1, 0, 0, 2,  2,  4);
      plan_access(16'h8000, 1, 'h0200, -128, 0, 1, 0, 2,  3,  5);  // data -128
      plan_access(16'h7F55, 1, 'h0355,  127, 0, 1, 0, 2,  4,  6);  // data +127
      // Lower the limit below frames already handed out: replace frame 0 only
      plan_limit(8'd1);
      plan_access(16'h1234, 1, 'h0034,   18, 0, 1, 1, 2,  5,  7);
      plan_access(16'h0000, 1, 'h0000,    0, 0, 1, 1, 2,  6,  8);  // page 0 was unmapped
      plan_access(16'hFF80, 1, 'h0180,   -1, 1, 0, 0, 3,  6,  9);  // frame 1 stays mapped
      // Oversized limit is clamped to the frame count: next free frame is 4
      plan_limit(8'd255);
      plan_access(16'hAA01, 1, 'h0401,  -86, 0, 1, 0, 3,  7, 10);
      // Victims rotate through frames 0 .. 2
      plan_limit(8'd3);
      plan_access(16'h1300, 1, 'h0000,   19, 0, 1, 1, 3,  8, 11);
      plan_access(16'h0001, 1, 'h0101,    0, 0, 1, 1, 3,  9, 12);
      plan_access(16'hFF02, 1, 'h0202,   -1, 0, 1, 1, 3, 10, 13);
      plan_access(16'h8003, 1, 'h0003, -128, 0, 1, 1, 3, 11, 14);
      // Victim pointer now past the new limit: wraps to frame 0
      plan_limit(8'd1);
      plan_access(16'h5000, 1, 'h0000,   80, 0, 1, 1, 3, 12, 15);
      // Zero limit behaves as one
      plan_limit(8'd0);
      plan_access(16'h7700, 1, 'h0000,  119, 0, 1, 1, 3, 13, 16);
      plan_limit(8'd128);
      plan_access(16'h5000, 1, 'h0500,   80, 0, 1, 0, 3, 14, 17);  // back to free frames
      plan_access(16'h7F55, 1, 'h0355,  127, 1, 0, 0, 4, 14, 18);  // old TLB entry survives
      plan_access(16'h4000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      plan_access(16'h40FF, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      plan_access(16'h3FFF, 0, 0, 0, 0, 0, 0, 0, 0, 0);

      // Hold reset, then release it on a falling edge
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_LIMIT) begin
            write_frame_limit(tlbpt_pkg::CFG_W'(directed_plan[i].value));
         end else begin
            send_address(directed_plan[i].value, directed_plan[i].typed,
                         directed_plan[i].want);
         end
      end

      // Random part: one limit per phase, extremes included. The first phase
      // spreads pages over the whole table.
      phase_limits = '{8'd128, 8'd255, 8'd1, 8'd0, 8'd2, 8'd127,
                       tlbpt_pkg::CFG_W'($urandom_range(3, 126)),
                       tlbpt_pkg::CFG_W'($urandom_range(129, 254)),
                       8'd128};
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         write_frame_limit(phase_limits[phase]);
         uniform_share = (phase == 0) ? 100 : 30;
         hot_base      = 8'($urandom_range(tlbpt_pkg::PAGE_COUNT - 1));
         repeat (PHASE_BEATS) begin
            // Drop the idle cycles for a long stretch in the middle of the run
            gaps_on = !(beats_sent >= 500 && beats_sent < 800);
            send_address(random_address(), 1'b0, '0);
         end
      end
      start <= 1'b0;

      // Wait for the last results, then let the pipeline settle
      while (pending_translations.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      if (error_count == 0 && pending_translations.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/tlbpt_pkg.sv
rtl/core/tlb_page_table_translator.sv
tb/tlb_page_table_translator_test.sv
